>>> design/glpd_pkg.sv
// Shared constants, types and command/status structures of the grid local peak detector.
package glpd_pkg;

  localparam int MAX_WIDTH_DEF = 32;

  localparam int PIX_W      = 16;
  localparam int ROW_W      = 12;
  localparam int PEAK_COL_W = 5;
  localparam int FW_W       = 6;
  localparam int FH_W       = 12;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 6'd32;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_CAP,
    ST_JUDGE,
    ST_FLUSH
  } glpd_state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_C
  } rd_phase_t;

  typedef struct packed {
    logic      accept;
    rd_phase_t rd_phase;
    logic      write_cur;
    logic      cap_a;
    logic      cap_b;
    logic      cap_c;
    logic      upd_marks;
    logic      emit_judge;
    logic      emit_flush;
    logic      flush_clr;
    logic      flush_inc;
    logic      retire;
  } glpd_cmd_t;

  typedef struct packed {
    logic judge_ok;
    logic do_flush;
    logic mark_bit;
    logic flush_end;
    logic out_free;
  } glpd_status_t;

endpackage

>>> design/grid_local_peak_detector_top.sv
// Top level of the grid local peak detector: registers, controller and datapath.
//
// Channel | Dir | Handshake                 | Word
// pixel   | in  | pixel_valid / pixel_stall | pixel_value
// peak    | out | peak_valid / peak_stall   | peak_row, peak_col, last_of_run
// config  | in  | APB write/read            | frame_width at 0x0, frame_height at 0x4
//
// Each pixel word passes through an accept step, three reads of the line stores
// (one read port per store), a step to capture and update the last-row marks, and a judge step.
// The final pixel of a frame adds a sweep of the mark bitmap across the frame width.
// A result waiting in the output register holds the sequence only when the next result
// is ready; the register otherwise frees the input side.
// Reset is synchronous and clears the counters, store rotation and state; no clearing pass.
module grid_local_peak_detector_top
  import glpd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  input  logic                    pixel_valid,
  output logic                    pixel_stall,
  input  logic signed [PIX_W-1:0] pixel_value,
  output logic                    peak_valid,
  input  logic                    peak_stall,
  output logic [ROW_W-1:0]        peak_row,
  output logic [PEAK_COL_W-1:0]   peak_col,
  output logic                    last_of_run
);

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  glpd_cmd_t       cmd;
  glpd_status_t    status;

  glpd_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height)
  );

  glpd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .status      (status),
    .cmd         (cmd)
  );

  glpd_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .pixel_value  (pixel_value),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .cmd          (cmd),
    .status       (status),
    .peak_stall   (peak_stall),
    .peak_valid   (peak_valid),
    .peak_row     (peak_row),
    .peak_col     (peak_col),
    .last_of_run  (last_of_run)
  );

endmodule

>>> design/glpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module glpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/glpd_regs.sv
// APB configuration registers for frame width and frame height.
module glpd_regs
  import glpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [FW_W-1:0]   frame_width,
  output logic [FH_W-1:0]   frame_height
);

  logic wr_strobe;

  assign pready    = 1'b1;
  assign wr_strobe = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (wr_strobe) begin
      unique case (paddr[2])
        REG_IDX_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_IDX_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_WIDTH:  prdata = APB_DW'(frame_width);
      REG_IDX_HEIGHT: prdata = APB_DW'(frame_height);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> design/glpd_ctrl.sv
// Controller state machine sequencing line store reads, judgement and last-row flush.
module glpd_ctrl
  import glpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         pixel_valid,
  output logic         pixel_stall,
  input  glpd_status_t status,
  output glpd_cmd_t    cmd
);

  glpd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.rd_phase = PH_A;
    pixel_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (pixel_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd.rd_phase  = PH_A;
        cmd.write_cur = 1'b1;
        state_next    = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_phase = PH_B;
        cmd.cap_a    = 1'b1;
        state_next   = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.rd_phase = PH_C;
        cmd.cap_b    = 1'b1;
        state_next   = ST_CAP;
      end
      ST_CAP: begin
        cmd.cap_c     = 1'b1;
        cmd.upd_marks = 1'b1;
        state_next    = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (!status.judge_ok || status.out_free) begin
          cmd.emit_judge = status.judge_ok;
          cmd.flush_clr  = 1'b1;
          if (status.do_flush) begin
            state_next = ST_FLUSH;
          end else begin
            cmd.retire = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (!status.mark_bit || status.out_free) begin
          cmd.emit_flush = status.mark_bit;
          if (status.flush_end) begin
            cmd.retire = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.flush_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/glpd_datapath.sv
// Datapath with rotating line stores, neighbour compares, last-row marks and the result register.
module glpd_datapath
  import glpd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [PIX_W-1:0] pixel_value,
  input  logic [FW_W-1:0]         frame_width,
  input  logic [FH_W-1:0]         frame_height,
  input  glpd_cmd_t               cmd,
  output glpd_status_t            status,
  input  logic                    peak_stall,
  output logic                    peak_valid,
  output logic [ROW_W-1:0]        peak_row,
  output logic [PEAK_COL_W-1:0]   peak_col,
  output logic                    last_of_run
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW = FW_W + 1;

  logic [ROW_W-1:0]        row_count;
  logic [CW-1:0]           col_count;
  logic [1:0]              rot;

  logic signed [PIX_W-1:0] pix;
  logic [CW-1:0]           col;
  logic [ROW_W-1:0]        row;
  logic [FW_W-1:0]         w;
  logic                    is_last;

  logic signed [PIX_W-1:0] a_one, a_two, a_cur, b_one, b_cur, c_one;
  logic [MAX_WIDTH-1:0]    marks;
  logic [CW-1:0]           fidx;

  logic [FW_W-1:0]         w_eff;
  logic [FH_W-1:0]         h_eff;
  logic [CW-1:0]           c_in;
  logic                    last_in;

  logic                    has_left, has_right, row_end;
  logic [CW-1:0]           c_m1, c_m2, c_p1;
  logic [CW-1:0]           cur_addr, one_addr, two_addr;
  logic [PIX_W-1:0]        rd_data [3];
  logic [PIX_W-1:0]        one_rd, two_rd, cur_rd;

  logic                    mk_left, mk_self;
  logic [MAX_WIDTH-1:0]    in_w, above;
  logic                    any_marks, rest_marks;

  // Effective frame geometry and the position of the incoming pixel.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = FW_W'(1);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff   = (frame_height == '0) ? FH_W'(1) : frame_height;
    c_in    = (XW'(col_count) >= XW'(w_eff)) ? CW'(w_eff - FW_W'(1)) : col_count;
    last_in = (row_count >= (h_eff - FH_W'(1)));
  end

  assign has_left  = (col != '0);
  assign has_right = ((XW'(col) + XW'(1)) < XW'(w));
  assign row_end   = ((XW'(col) + XW'(1)) == XW'(w));
  assign c_m1      = has_left ? (col - CW'(1)) : '0;
  assign c_m2      = (XW'(col) > XW'(1)) ? CW'(XW'(col) - XW'(2)) : '0;
  assign c_p1      = has_right ? CW'(XW'(col) + XW'(1)) : col;

  always_comb begin
    cur_addr = c_m1;
    one_addr = col;
    two_addr = col;
    unique case (cmd.rd_phase)
      PH_A: begin
        cur_addr = c_m1;
        one_addr = col;
      end
      PH_B: begin
        cur_addr = c_m2;
        one_addr = c_m1;
      end
      PH_C: begin
        cur_addr = c_m1;
        one_addr = c_p1;
      end
      default: ;
    endcase
  end

  // Three physical stores rotate through the current, one-above and two-above roles.
  for (genvar k = 0; k < 3; k++) begin : g_line
    logic          is_cur, is_one;
    logic [CW-1:0] rd_addr;

    assign is_cur  = (rot == 2'(k));
    assign is_one  = (rot == 2'((k + 1) % 3));
    assign rd_addr = is_cur ? cur_addr : (is_one ? one_addr : two_addr);

    glpd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk     (clk),
      .wr_en   (cmd.write_cur && is_cur),
      .wr_addr (col),
      .wr_data (pix),
      .rd_addr (rd_addr),
      .rd_data (rd_data[k])
    );
  end

  always_comb begin
    unique case (rot)
      2'd0: begin
        cur_rd = rd_data[0];
        one_rd = rd_data[2];
        two_rd = rd_data[1];
      end
      2'd1: begin
        cur_rd = rd_data[1];
        one_rd = rd_data[0];
        two_rd = rd_data[2];
      end
      2'd2: begin
        cur_rd = rd_data[2];
        one_rd = rd_data[1];
        two_rd = rd_data[0];
      end
      default: begin
        cur_rd = rd_data[0];
        one_rd = rd_data[2];
        two_rd = rd_data[1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix     <= pixel_value;
      col     <= c_in;
      row     <= row_count;
      w       <= w_eff;
      is_last <= last_in;
    end
    if (cmd.cap_a) begin
      a_one <= $signed(one_rd);
      a_two <= $signed(two_rd);
      a_cur <= $signed(cur_rd);
    end
    if (cmd.cap_b) begin
      b_one <= $signed(one_rd);
      b_cur <= $signed(cur_rd);
    end
    if (cmd.cap_c) begin
      c_one <= $signed(one_rd);
    end
  end

  // Last-row peak marks: the left neighbour of this pixel is now complete, and so is
  // this pixel itself when it closes the row.
  assign mk_left = !(((XW'(col) > XW'(1)) && (b_cur > a_cur)) || (pix > a_cur) ||
                     ((row != '0) && (b_one > a_cur)));
  assign mk_self = !((has_left && (a_cur > pix)) || ((row != '0) && (a_one > pix)));

  always_ff @(posedge clk) begin
    if (cmd.upd_marks && is_last) begin
      if (has_left) begin
        marks[c_m1] <= mk_left;
      end
      if (row_end) begin
        marks[col] <= mk_self;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_WIDTH; k++) begin
      in_w[k]  = (XW'(k) < XW'(w));
      above[k] = (XW'(k) > XW'(fidx));
    end
    any_marks  = |(marks & in_w);
    rest_marks = |(marks & in_w & above);
  end

  always_comb begin
    status.judge_ok  = (row != '0) && !(pix > a_one) &&
                       !((row > ROW_W'(1)) && (a_two > a_one)) &&
                       !(has_left && (b_one > a_one)) &&
                       !(has_right && (c_one > a_one));
    status.do_flush  = is_last && row_end;
    status.mark_bit  = marks[fidx];
    status.flush_end = ((XW'(fidx) + XW'(1)) == XW'(w));
    status.out_free  = !peak_valid || !peak_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      rot       <= '0;
      fidx      <= '0;
    end else begin
      if (cmd.flush_clr) begin
        fidx <= '0;
      end else if (cmd.flush_inc) begin
        fidx <= fidx + CW'(1);
      end
      if (cmd.retire) begin
        if (row_end) begin
          col_count <= '0;
          row_count <= is_last ? '0 : (row + ROW_W'(1));
          rot       <= (rot == 2'd2) ? 2'd0 : (rot + 2'd1);
        end else begin
          col_count <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (cmd.emit_judge || cmd.emit_flush) begin
      peak_valid <= 1'b1;
    end else if (!peak_stall) begin
      peak_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_judge) begin
      peak_row    <= row - ROW_W'(1);
      peak_col    <= PEAK_COL_W'(col);
      last_of_run <= !(status.do_flush && any_marks);
    end else if (cmd.emit_flush) begin
      peak_row    <= row;
      peak_col    <= PEAK_COL_W'(fidx);
      last_of_run <= !rest_marks;
    end
  end

endmodule
